// ===== design/obbcp_pkg.sv =====
// Shared widths, register indexes and reset values for the oriented box closest point query.
`default_nettype none
package obbcp_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned AxisW   = 16;
  localparam int unsigned ExtW    = 31;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned ProdW   = DiffW + AxisW;
  localparam int unsigned ProjW   = ProdW + 1;
  localparam int unsigned TermW   = ProjW + AxisW;
  localparam int unsigned HalfSh  = 13;
  localparam int unsigned FracSh  = 28;
  localparam int unsigned DistW   = 64;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  localparam logic [CfgIdxW-1:0] CfgCenterX = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgCenterY = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgAxisUX  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgAxisUY  = 8'd3;
  localparam logic [CfgIdxW-1:0] CfgAxisVX  = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgAxisVY  = 8'd5;
  localparam logic [CfgIdxW-1:0] CfgExtentU = 8'd6;
  localparam logic [CfgIdxW-1:0] CfgExtentV = 8'd7;

  localparam logic signed [AxisW-1:0] AxisOne  = 16'sd16384;
  localparam logic signed [AxisW-1:0] AxisZero = 16'sd0;

  typedef struct packed {
    logic en;
  } pipe_ctrl_t;

endpackage
`default_nettype wire

// ===== design/obbcp_axis_lane.sv =====
// Three-stage projection, clamp and scale of the center offset along one box axis.
`default_nettype none
module obbcp_axis_lane (
  input  wire                                        clk_i,
  input  wire obbcp_pkg::pipe_ctrl_t                 ctrl_i,
  input  wire logic signed [obbcp_pkg::DiffW-1:0]    dx_i,
  input  wire logic signed [obbcp_pkg::DiffW-1:0]    dy_i,
  input  wire logic signed [obbcp_pkg::AxisW-1:0]    ax_i,
  input  wire logic signed [obbcp_pkg::AxisW-1:0]    ay_i,
  input  wire logic        [obbcp_pkg::ExtW-1:0]     ext_i,
  output logic signed      [obbcp_pkg::TermW-1:0]    tx_o,
  output logic signed      [obbcp_pkg::TermW-1:0]    ty_o
);

  logic signed [obbcp_pkg::ProdW-1:0] px_q, py_q;
  logic signed [obbcp_pkg::ProjW-1:0] proj, lim, pc_d, pc_q;
  logic signed [obbcp_pkg::TermW-1:0] tx_q, ty_q;

  always_comb begin
    proj = obbcp_pkg::ProjW'(px_q) + obbcp_pkg::ProjW'(py_q);
    lim  = $signed({{(obbcp_pkg::ProjW - obbcp_pkg::ExtW - obbcp_pkg::HalfSh){1'b0}},
                    ext_i, {obbcp_pkg::HalfSh{1'b0}}});
    priority if (proj > lim) begin
      pc_d = lim;
    end else if (proj < -lim) begin
      pc_d = -lim;
    end else begin
      pc_d = proj;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      px_q <= dx_i * ax_i;
      py_q <= dy_i * ay_i;
      pc_q <= pc_d;
      tx_q <= ax_i * pc_q;
      ty_q <= ay_i * pc_q;
    end
  end

  assign tx_o = tx_q;
  assign ty_o = ty_q;

endmodule
`default_nettype wire

// ===== design/obb2d_closest_point_query.sv =====
// Streaming closest point on a 2D oriented box with squared distance, fully pipelined.
//
// Query points arrive on the s_axis channel, one transaction per point, and
// results leave on the m_axis channel in the same order, one per point.
// The box is set through the cfg write channel (index 0..7: center x/y,
// axis u x/y, axis v x/y, extent u/v); writes to other indexes are dropped.
// Configuration is meant to change only while no query is in flight.
// The datapath is a nine-stage pipeline: offset, axis products, clamp,
// axis scaling, term sum, rounding with saturation, difference, squaring
// and the distance sum in the output register. One point is taken every
// cycle while s_axis_tready is high.
// A skid register behind the output register parts the two sides, so
// s_axis_tready is registered and drops only once the output is stalled
// and the skid register is full; nothing is lost or repeated on a stall.
// Reset empties the pipeline and loads the default box: unit axes along
// x and y, zero extents and center at the origin.
`default_nettype none
module obb2d_closest_point_query (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,  // point_x [31:0], point_y [63:32]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [127:0] m_axis_tdata  // closest_x [31:0], closest_y [63:32], sq_distance [127:64]
);

  localparam int unsigned CW = obbcp_pkg::CoordW;
  localparam int unsigned DW = obbcp_pkg::DiffW;
  localparam int unsigned TW = obbcp_pkg::TermW;
  localparam int unsigned SumW = TW + 1;
  localparam int unsigned AccW = TW + 2;
  localparam int unsigned ShW = AccW - obbcp_pkg::FracSh;
  localparam int unsigned QW = obbcp_pkg::DistW;
  localparam int unsigned NStg = 8;
  localparam int unsigned PtStg = 6;

  logic signed [CW-1:0] center_x_q, center_y_q;
  logic signed [obbcp_pkg::AxisW-1:0] axis_ux_q, axis_uy_q, axis_vx_q, axis_vy_q;
  logic [obbcp_pkg::ExtW-1:0] extent_u_q, extent_v_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      axis_ux_q  <= obbcp_pkg::AxisOne;
      axis_uy_q  <= obbcp_pkg::AxisZero;
      axis_vx_q  <= obbcp_pkg::AxisZero;
      axis_vy_q  <= obbcp_pkg::AxisOne;
      extent_u_q <= '0;
      extent_v_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        obbcp_pkg::CfgCenterX: center_x_q <= $signed(cfg_data_i);
        obbcp_pkg::CfgCenterY: center_y_q <= $signed(cfg_data_i);
        obbcp_pkg::CfgAxisUX:  axis_ux_q  <= $signed(cfg_data_i[15:0]);
        obbcp_pkg::CfgAxisUY:  axis_uy_q  <= $signed(cfg_data_i[15:0]);
        obbcp_pkg::CfgAxisVX:  axis_vx_q  <= $signed(cfg_data_i[15:0]);
        obbcp_pkg::CfgAxisVY:  axis_vy_q  <= $signed(cfg_data_i[15:0]);
        obbcp_pkg::CfgExtentU: extent_u_q <= cfg_data_i[obbcp_pkg::ExtW-1:0];
        obbcp_pkg::CfgExtentV: extent_v_q <= cfg_data_i[obbcp_pkg::ExtW-1:0];
        default: ;
      endcase
    end
  end

  obbcp_pkg::pipe_ctrl_t ctrl;
  logic skid_v_q, out_v_q;
  logic [NStg:1] v_q;

  assign ctrl.en = !skid_v_q;
  assign s_axis_tready = ctrl.en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctrl.en) begin
      v_q <= {v_q[NStg-1:1], s_axis_tvalid};
    end
  end

  logic signed [CW-1:0] ptx_q [1:PtStg];
  logic signed [CW-1:0] pty_q [1:PtStg];
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [TW-1:0] tux, tuy, tvx, tvy;
  logic signed [SumW-1:0] sx_q, sy_q;
  logic signed [CW-1:0] cx_d, cy_d, cx_q, cy_q, cx6_q, cy6_q;
  logic [CW-1:0] mx_d, my_d, mx_q, my_q;
  logic [QW-1:0] qx_q, qy_q;

  function automatic logic signed [CW-1:0] round_sat(
    input logic signed [SumW-1:0] s,
    input logic signed [CW-1:0]   c
  );
    logic signed [AccW-1:0] acc;
    logic signed [ShW-1:0]  sh;
    acc = AccW'(s) + (AccW'(c) <<< obbcp_pkg::FracSh)
        + (AccW'(1) <<< (obbcp_pkg::FracSh - 1));
    sh = ShW'(acc >>> obbcp_pkg::FracSh);
    if (sh > ShW'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (sh < ShW'(signed'({1'b1, {(CW-1){1'b0}}}))) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return sh[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] abs_diff(
    input logic signed [CW-1:0] a,
    input logic signed [CW-1:0] b
  );
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    return d[DW-1] ? CW'(-d) : d[CW-1:0];
  endfunction

  always_comb begin
    cx_d = round_sat(sx_q, center_x_q);
    cy_d = round_sat(sy_q, center_y_q);
    mx_d = abs_diff(cx6_q, ptx_q[PtStg]);
    my_d = abs_diff(cy6_q, pty_q[PtStg]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en) begin
      ptx_q[1] <= $signed(s_axis_tdata[CW-1:0]);
      pty_q[1] <= $signed(s_axis_tdata[2*CW-1:CW]);
      for (int i = 2; i <= PtStg; i++) begin
        ptx_q[i] <= ptx_q[i-1];
        pty_q[i] <= pty_q[i-1];
      end
      dx_q  <= DW'($signed(s_axis_tdata[CW-1:0])) - DW'(center_x_q);
      dy_q  <= DW'($signed(s_axis_tdata[2*CW-1:CW])) - DW'(center_y_q);
      sx_q  <= SumW'(tux) + SumW'(tvx);
      sy_q  <= SumW'(tuy) + SumW'(tvy);
      cx6_q <= cx_d;
      cy6_q <= cy_d;
      cx_q  <= cx6_q;
      cy_q  <= cy6_q;
      mx_q  <= mx_d;
      my_q  <= my_d;
      qx_q  <= QW'(mx_q) * QW'(mx_q);
      qy_q  <= QW'(my_q) * QW'(my_q);
    end
  end

  obbcp_axis_lane u_lane_u (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .ax_i   (axis_ux_q),
    .ay_i   (axis_uy_q),
    .ext_i  (extent_u_q),
    .tx_o   (tux),
    .ty_o   (tuy)
  );

  obbcp_axis_lane u_lane_v (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .ax_i   (axis_vx_q),
    .ay_i   (axis_vy_q),
    .ext_i  (extent_v_q),
    .tx_o   (tvx),
    .ty_o   (tvy)
  );

  // The closest point waits two stages beside the difference and square.
  logic signed [CW-1:0] cx7_q, cy7_q;
  logic [QW:0] qsum;
  logic [127:0] res_d, out_q, skid_q;
  logic new_v;

  always_ff @(posedge clk_i) begin
    if (ctrl.en) begin
      cx7_q <= cx_q;
      cy7_q <= cy_q;
    end
  end

  always_comb begin
    qsum  = (QW+1)'(qx_q) + (QW+1)'(qy_q);
    res_d = {(qsum[QW] ? {QW{1'b1}} : qsum[QW-1:0]), cy7_q, cx7_q};
    new_v = ctrl.en && v_q[NStg];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (m_axis_tready || !out_v_q) begin
      out_v_q  <= skid_v_q || new_v;
      skid_v_q <= 1'b0;
    end else if (new_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tready || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (new_v) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
    else $error("skid register filled without an output stall");

  a_last_stage_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.en && v_q[NStg]) |=> out_v_q)
    else $error("result leaving the pipeline was dropped");

endmodule
`default_nettype wire
